@@ rtl/i2c_master_register_transfer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// I2C master register transfer unit: assertion macros
// Shared macros for the concurrent assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_TRANSFER_UNIT_MACROS_SVH
`define I2C_MASTER_REGISTER_TRANSFER_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define I2CM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is also checked while reset is high.
`define I2CM_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master register transfer unit: package
// Types, bus status codes and packed transaction layouts.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_START_WRITE = 2'd0,
      OP_START_READ  = 2'd1,
      OP_EVENT       = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      OUTC_BUSY      = 2'd0,
      OUTC_NACK      = 2'd1,
      OUTC_BUS_ERROR = 2'd2,
      OUTC_DONE      = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ACK_KEEP = 2'd0,
      ACK_ACK  = 2'd1,
      ACK_NACK = 2'd2
   } ack_type;

   // Byte-level bus controller status codes.
   localparam logic [7:0] SC_BUS_ERROR    = 8'h00;
   localparam logic [7:0] SC_START        = 8'h08;
   localparam logic [7:0] SC_RESTART      = 8'h10;
   localparam logic [7:0] SC_SLA_W_ACK    = 8'h18;
   localparam logic [7:0] SC_SLA_W_NACK   = 8'h20;
   localparam logic [7:0] SC_DATA_TX_ACK  = 8'h28;
   localparam logic [7:0] SC_DATA_TX_NACK = 8'h30;
   localparam logic [7:0] SC_ARB_LOST     = 8'h38;
   localparam logic [7:0] SC_SLA_R_ACK    = 8'h40;
   localparam logic [7:0] SC_SLA_R_NACK   = 8'h48;
   localparam logic [7:0] SC_DATA_RX_ACK  = 8'h50;
   localparam logic [7:0] SC_DATA_RX_NACK = 8'h58;

   localparam logic [7:0] READ_ADDR_MASK  = 8'hfe;
   localparam logic [7:0] WRITE_ADDR_MASK = 8'hff;

   // Input transaction payload, last field in the lowest bits.
   typedef struct packed {
      logic [7:0] tx_data;
      logic [7:0] rx_data;
      logic [7:0] status_code;
      logic [7:0] byte_count;
      logic [7:0] start_register;
      logic [7:0] dev_address;
   } req_type;

   // Result transaction payload, last field in the lowest bits.
   typedef struct packed {
      logic [4:0] pad;
      logic [1:0] outcome;
      logic [7:0] buffer_pos;
      logic       rx_store;
      logic       event_clear;
      logic [1:0] ack_action;
      logic       stop_clear;
      logic       stop_set;
      logic       start_clear;
      logic       start_set;
      logic [7:0] send_byte;
      logic       send_valid;
   } rsp_type;

endpackage

@@ rtl/i2cm_core.sv @@
// ----------------------------------------------------------------------------
// I2C master register transfer unit: sequencer core
// Holds the transfer state and decodes one command or bus status event into
// controller actions, updating the state when the step is taken.
// ----------------------------------------------------------------------------
module i2cm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  i2cm_pkg::op_type op,
   input  i2cm_pkg::req_type item,
   output i2cm_pkg::rsp_type result
);
   import i2cm_pkg::*;

   logic [7:0]  target_address_ff, target_address_in;
   logic [7:0]  register_index_ff, register_index_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic        reading_ff, reading_in;
   logic [7:0]  position_ff, position_in;
   outcome_type status_ff, status_in;

   always_comb begin
      target_address_in = target_address_ff;
      register_index_in = register_index_ff;
      remaining_in      = remaining_ff;
      reading_in        = reading_ff;
      position_in       = position_ff;
      status_in         = status_ff;
      result            = '0;
      result.buffer_pos = position_ff;

      unique case (op)
         OP_START_WRITE, OP_START_READ: begin
            reading_in        = (op == OP_START_READ);
            target_address_in = item.dev_address &
               ((op == OP_START_READ) ? READ_ADDR_MASK : WRITE_ADDR_MASK);
            register_index_in = item.start_register;
            remaining_in      = item.byte_count;
            position_in       = '0;
            status_in         = OUTC_BUSY;
            result.start_set  = 1'b1;
            result.buffer_pos = '0;
         end
         OP_EVENT: begin
            unique case (item.status_code) inside
               SC_START, SC_RESTART: begin
                  result.send_valid  = 1'b1;
                  result.send_byte   = target_address_ff;
                  result.start_clear = 1'b1;
                  result.event_clear = 1'b1;
               end
               SC_SLA_W_ACK: begin
                  result.send_valid  = 1'b1;
                  result.send_byte   = register_index_ff;
                  result.start_clear = 1'b1;
                  result.event_clear = 1'b1;
               end
               SC_SLA_W_NACK, SC_DATA_TX_NACK, SC_SLA_R_NACK: begin
                  result.stop_set    = 1'b1;
                  result.start_clear = 1'b1;
                  result.event_clear = 1'b1;
                  status_in          = OUTC_NACK;
               end
               SC_DATA_TX_ACK: begin
                  if (reading_ff) begin
                     // Register index is out: turn round with a repeated start.
                     target_address_in  = target_address_ff | 8'h01;
                     result.start_set   = 1'b1;
                     result.event_clear = 1'b1;
                  end else if (remaining_ff != '0) begin
                     result.send_valid  = 1'b1;
                     result.send_byte   = item.tx_data;
                     position_in        = position_ff + 8'd1;
                     remaining_in       = remaining_ff - 8'd1;
                     result.start_clear = 1'b1;
                     result.event_clear = 1'b1;
                  end else begin
                     result.stop_set    = 1'b1;
                     result.start_clear = 1'b1;
                     result.event_clear = 1'b1;
                     status_in          = OUTC_DONE;
                  end
               end
               SC_ARB_LOST: begin
                  result.start_set   = 1'b1;
                  result.stop_clear  = 1'b1;
                  result.event_clear = 1'b1;
               end
               SC_SLA_R_ACK: begin
                  remaining_in       = remaining_ff - 8'd1;
                  result.ack_action  = (remaining_in != '0) ? ACK_ACK : ACK_NACK;
                  result.start_clear = 1'b1;
                  result.event_clear = 1'b1;
               end
               SC_DATA_RX_ACK: begin
                  remaining_in       = remaining_ff - 8'd1;
                  result.ack_action  = (remaining_in != '0) ? ACK_ACK : ACK_NACK;
                  result.rx_store    = 1'b1;
                  position_in        = position_ff + 8'd1;
                  result.start_clear = 1'b1;
                  result.event_clear = 1'b1;
               end
               SC_DATA_RX_NACK: begin
                  result.rx_store    = 1'b1;
                  position_in        = position_ff + 8'd1;
                  result.stop_set    = 1'b1;
                  result.start_clear = 1'b1;
                  result.event_clear = 1'b1;
                  status_in          = OUTC_DONE;
               end
               SC_BUS_ERROR: begin
                  result.stop_set    = 1'b1;
                  result.start_clear = 1'b1;
                  result.event_clear = 1'b1;
                  status_in          = OUTC_BUS_ERROR;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      result.outcome = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff <= '0;
         register_index_ff <= '0;
         remaining_ff      <= '0;
         reading_ff        <= 1'b0;
         position_ff       <= '0;
         status_ff         <= OUTC_BUSY;
      end else if (step) begin
         target_address_ff <= target_address_in;
         register_index_ff <= register_index_in;
         remaining_ff      <= remaining_in;
         reading_ff        <= reading_in;
         position_ff       <= position_in;
         status_ff         <= status_in;
      end
   end

endmodule

@@ rtl/i2c_master_register_transfer_unit.sv @@
// Path: an accepted transaction is held in the input register, then its result
// in the result register; a stall on the result side holds both.
// Throughput: one transaction per cycle when not stalled; the sequencer decode
// sits between the two registers and updates the transfer state in the same cycle.
// Reset: synchronous, active high; clears both valid flags and the transfer
// state (outcome busy, position and count zero).
// ----------------------------------------------------------------------------
// I2C master register transfer unit
// Stream wrapper around the status-code sequencer with registered input and
// output stages and back-pressure from the result side.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // dev_address, start_register, byte_count, status_code, rx_data, tx_data
   input  logic [i2cm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  logic [i2cm_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // send_valid, send_byte, start_set, start_clear, stop_set, stop_clear,
   // ack_action, event_clear, rx_store, buffer_pos, outcome, zero fill
   output logic [i2cm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import i2cm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   op_type  in_op_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_result;
   logic    out_advance;
   logic    step;

   assign out_advance = !rsp_valid_ff || rsp_tready;
   assign step        = in_valid_ff && out_advance;
   assign req_tready  = !in_valid_ff || out_advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = out_advance ? in_valid_ff : rsp_valid_ff;

   i2cm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .op     (in_op_ff),
      .item   (in_item_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_type'(req_tdata);
         in_op_ff   <= op_type'(req_tuser);
      end
      if (step) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// I2C master register transfer unit: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_register_transfer_unit_macros.svh"

module i2cm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [i2cm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import i2cm_pkg::*;

   // A stalled result must stay put.
   `I2CM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // After reset the block is empty and ready for a transaction.
   `I2CM_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid && req_tready, "block not empty after reset")

   // No byte is presented unless one is loaded for transmission.
   `I2CM_ASSERT(a_send_byte_zero, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'h00, "send byte without send valid")

   // Start is never requested and withdrawn in the same step.
   `I2CM_ASSERT(a_start_excl, rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[10]), "start set and clear together")

   // A stored receive byte always comes with an acknowledge decision or a stop.
   `I2CM_ASSERT(a_rx_store_act, rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15] && (rsp_tdata[14:13] != ACK_KEEP || rsp_tdata[11]), "receive store without action")

endmodule

bind i2c_master_register_transfer_unit i2cm_checker u_checker (.*);
